>>> rtl/core/swps_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and defaults of the sorted window point search core
package swps_pkg;

	// defaults handed to the top level parameters
	localparam int DEF_MAX_POINTS  = 1024;
	localparam int DEF_COORD_BITS  = 20;
	localparam int DEF_MAX_MATCHES = 63;

	// fixed field widths
	localparam int REQ_TYPE_BITS = 2;
	localparam int INDEX_BITS    = 10;
	localparam int OUT_USER_BITS = 2;

	// depth of the command queue between front and back
	localparam int CMD_QUEUE_DEPTH = 2;

	// request codes on the input tuser
	localparam logic [REQ_TYPE_BITS-1:0] REQ_CLEAR  = 2'd0;
	localparam logic [REQ_TYPE_BITS-1:0] REQ_APPEND = 2'd1;
	localparam logic [REQ_TYPE_BITS-1:0] REQ_QUERY  = 2'd2;

	typedef enum logic [1:0] {
		CMD_CLEAR,
		CMD_APPEND,
		CMD_QUERY
	} cmd_kind_t;

	// queue head as seen by the back end
	typedef struct packed {
		logic      valid;
		cmd_kind_t kind;
	} cmd_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_PROBE,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_DRAIN,
		ST_SUMMARY
	} back_state_t;

endpackage

>>> rtl/core/swps_ram.sv
`timescale 1ns / 1ps
// generic single write, single read ram with registered read data
module swps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/swps_front.sv
`timescale 1ns / 1ps
// front end: takes request words, decodes them, precomputes window bounds, queues commands
module swps_front #(
	parameter int COORD_BITS   = swps_pkg::DEF_COORD_BITS,
	parameter int IN_DATA_BITS = ((5 * COORD_BITS - 1 + 7) / 8) * 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [IN_DATA_BITS-1:0]          s_tdata,
	input  logic [swps_pkg::REQ_TYPE_BITS-1:0] s_tuser,
	output swps_pkg::cmd_ctrl_t              cmd,
	input  logic                             cmd_ready,
	output logic [COORD_BITS-1:0]            cmd_a_u,
	output logic [COORD_BITS-1:0]            cmd_a_v,
	output logic signed [COORD_BITS:0]       cmd_ulb,
	output logic signed [COORD_BITS:0]       cmd_urb,
	output logic signed [COORD_BITS:0]       cmd_vlb,
	output logic signed [COORD_BITS:0]       cmd_vub
);
	import swps_pkg::*;

	localparam int CB  = COORD_BITS;
	localparam int QD  = CMD_QUEUE_DEPTH;
	localparam int QAW = $clog2(QD);
	localparam int QCW = $clog2(QD + 1);

	logic [CB-1:0]   pu, pv, qu, qv;
	logic [CB-2:0]   rad;
	logic signed [CB:0] qu_x, qv_x, r_x;
	cmd_kind_t       kind;
	logic            known;
	logic            take, push, pop;

	cmd_kind_t       kind_mem [QD];
	logic [CB-1:0]   au_mem   [QD];
	logic [CB-1:0]   av_mem   [QD];
	logic signed [CB:0] ulb_mem [QD];
	logic signed [CB:0] urb_mem [QD];
	logic signed [CB:0] vlb_mem [QD];
	logic signed [CB:0] vub_mem [QD];

	logic [QAW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0]  cnt_q;

	assign pu  = s_tdata[CB-1:0];
	assign pv  = s_tdata[2*CB-1:CB];
	assign qu  = s_tdata[3*CB-1:2*CB];
	assign qv  = s_tdata[4*CB-1:3*CB];
	assign rad = s_tdata[5*CB-2:4*CB];

	assign qu_x = {qu[CB-1], qu};
	assign qv_x = {qv[CB-1], qv};
	assign r_x  = {2'b00, rad};

	// classify the request, the unused code is swallowed
	always_comb begin
		kind  = CMD_CLEAR;
		known = 1'b1;
		unique case (s_tuser)
			REQ_CLEAR:  kind = CMD_CLEAR;
			REQ_APPEND: kind = CMD_APPEND;
			REQ_QUERY:  kind = CMD_QUERY;
			default:    known = 1'b0;
		endcase
	end

	assign s_tready = (cnt_q != QCW'(QD));
	assign take     = s_tvalid && s_tready;
	assign push     = take && known;
	assign pop      = cmd.valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			kind_mem[wr_ptr_q] <= kind;
			au_mem[wr_ptr_q]   <= (kind == CMD_APPEND) ? pu : qu;
			av_mem[wr_ptr_q]   <= (kind == CMD_APPEND) ? pv : qv;
			ulb_mem[wr_ptr_q]  <= qu_x - r_x;
			urb_mem[wr_ptr_q]  <= qu_x + r_x;
			vlb_mem[wr_ptr_q]  <= qv_x - r_x;
			vub_mem[wr_ptr_q]  <= qv_x + r_x;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign cmd.valid = (cnt_q != '0);
	assign cmd.kind  = kind_mem[rd_ptr_q];
	assign cmd_a_u   = au_mem[rd_ptr_q];
	assign cmd_a_v   = av_mem[rd_ptr_q];
	assign cmd_ulb   = ulb_mem[rd_ptr_q];
	assign cmd_urb   = urb_mem[rd_ptr_q];
	assign cmd_vlb   = vlb_mem[rd_ptr_q];
	assign cmd_vub   = vub_mem[rd_ptr_q];

endmodule

>>> rtl/core/swps_back.sv
`timescale 1ns / 1ps
// back end: point table, binary search and scan sequencer, output word register
module swps_back #(
	parameter int MAX_POINTS    = swps_pkg::DEF_MAX_POINTS,
	parameter int COORD_BITS    = swps_pkg::DEF_COORD_BITS,
	parameter int MAX_MATCHES   = swps_pkg::DEF_MAX_MATCHES,
	parameter int OUT_DATA_BITS = ((3 * COORD_BITS + 11 + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  swps_pkg::cmd_ctrl_t               cmd,
	output logic                              cmd_ready,
	input  logic [COORD_BITS-1:0]             cmd_a_u,
	input  logic [COORD_BITS-1:0]             cmd_a_v,
	input  logic signed [COORD_BITS:0]        cmd_ulb,
	input  logic signed [COORD_BITS:0]        cmd_urb,
	input  logic signed [COORD_BITS:0]        cmd_vlb,
	input  logic signed [COORD_BITS:0]        cmd_vub,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [OUT_DATA_BITS-1:0]          m_tdata,
	output logic [swps_pkg::OUT_USER_BITS-1:0] m_tuser,
	output logic                              m_tlast
);
	import swps_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int SW = CW + 1;
	localparam int EW = $clog2(MAX_MATCHES + 1);

	back_state_t        state_q, state_d;
	logic [CW-1:0]      count_q;

	// query context
	logic [CB-1:0]      qu_q, qv_q;
	logic signed [CB:0] ulb_q, urb_q, vlb_q, vub_q;
	logic signed [SW-1:0] left_q, right_q, mid_q, i_q;
	logic               pass_q;
	logic [EW-1:0]      emit_cnt_q;
	logic               found_q, over_q;
	logic [CB:0]        best_q;
	logic               match_s1;
	logic [CB:0]        man_dist_s1;

	// output word register
	logic               out_valid_q;
	logic [CB-1:0]      out_u_q, out_v_q;
	logic [INDEX_BITS-1:0] out_idx_q;
	logic [CB:0]        out_dist_q;
	logic               out_found_q, out_over_q, out_last_q;

	// ram port
	logic               ram_we, ram_re;
	logic [AW-1:0]      ram_raddr;
	logic [2*CB-1:0]    ram_rdata;
	logic [CB-1:0]      u_rd, v_rd;

	logic [SW:0]        mid_sum;
	logic signed [SW-1:0] mid;
	logic signed [CB:0] u_ext, v_ext, qu_ext, qv_ext, du, dv, du_neg, dv_neg;
	logic [CB-1:0]      adu, adv;
	logic [CB:0]        man_dist;
	logic               u_lo, u_hi, v_in, scan_cont, is_match, need_emit;
	logic               search_go, idx_ok, out_free, chk_stall;
	logic               load_match, load_sum;
	logic [INDEX_BITS+SW-1:0] idx_wide;

	swps_ram #(
		.WIDTH(2 * CB),
		.DEPTH(MAX_POINTS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[AW-1:0]),
		.wdata({cmd_a_v, cmd_a_u}),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign u_rd = ram_rdata[CB-1:0];
	assign v_rd = ram_rdata[2*CB-1:CB];

	// midpoint of a non-empty interval, both ends non-negative there
	assign mid_sum = {left_q[SW-1], left_q} + {right_q[SW-1], right_q};
	assign mid     = mid_sum[SW:1];

	assign u_ext  = {u_rd[CB-1], u_rd};
	assign v_ext  = {v_rd[CB-1], v_rd};
	assign qu_ext = {qu_q[CB-1], qu_q};
	assign qv_ext = {qv_q[CB-1], qv_q};

	assign u_lo = (u_ext < ulb_q);
	assign u_hi = (u_ext > urb_q);
	assign v_in = (v_ext > vlb_q) && (v_ext < vub_q);

	// manhattan distance, registered before the running minimum
	assign du       = u_ext - qu_ext;
	assign dv       = v_ext - qv_ext;
	assign du_neg   = -du;
	assign dv_neg   = -dv;
	assign adu      = du[CB] ? du_neg[CB-1:0] : du[CB-1:0];
	assign adv      = dv[CB] ? dv_neg[CB-1:0] : dv[CB-1:0];
	assign man_dist = {1'b0, adu} + {1'b0, adv};

	assign search_go = (left_q <= right_q);
	assign idx_ok    = pass_q ? (i_q >= left_q) : (i_q <= right_q);
	assign scan_cont = pass_q ? !u_lo : !u_hi;
	assign is_match  = scan_cont && v_in;
	assign need_emit = is_match && (emit_cnt_q < EW'(MAX_MATCHES));
	assign out_free  = !out_valid_q || m_tready;
	assign chk_stall = need_emit && !out_free;

	assign idx_wide = {{INDEX_BITS{1'b0}}, i_q};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.valid && cmd.kind == CMD_QUERY) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				state_d = search_go ? ST_PROBE : ST_DRAIN;
			end
			ST_PROBE: begin
				state_d = (u_lo || u_hi) ? ST_SEARCH : ST_SCAN_RD;
			end
			ST_SCAN_RD: begin
				if (idx_ok) begin
					state_d = ST_SCAN_CHK;
				end else begin
					state_d = pass_q ? ST_DRAIN : ST_SCAN_RD;
				end
			end
			ST_SCAN_CHK: begin
				if (chk_stall) begin
					state_d = ST_SCAN_CHK;
				end else if (scan_cont || !pass_q) begin
					state_d = ST_SCAN_RD;
				end else begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_SUMMARY;
			end
			ST_SUMMARY: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		cmd_ready  = 1'b0;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_raddr  = mid[AW-1:0];
		load_match = 1'b0;
		load_sum   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd_ready = 1'b1;
				ram_we    = cmd.valid && (cmd.kind == CMD_APPEND) &&
				            (count_q < CW'(MAX_POINTS));
			end
			ST_SEARCH: begin
				ram_re = search_go;
			end
			ST_SCAN_RD: begin
				ram_re    = idx_ok;
				ram_raddr = i_q[AW-1:0];
			end
			ST_SCAN_CHK: begin
				load_match = need_emit && out_free;
			end
			ST_SUMMARY: begin
				load_sum = out_free;
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && cmd.valid && cmd.kind == CMD_CLEAR) begin
				count_q <= '0;
			end else if (ram_we) begin
				count_q <= count_q + CW'(1);
			end
			if (load_match || load_sum) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// query datapath
	always_ff @(posedge clk) begin
		match_s1    <= (state_q == ST_SCAN_CHK) && !chk_stall && is_match;
		man_dist_s1 <= man_dist;
		if (match_s1 && (man_dist_s1 < best_q)) begin
			best_q <= man_dist_s1;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.valid && cmd.kind == CMD_QUERY) begin
					qu_q       <= cmd_a_u;
					qv_q       <= cmd_a_v;
					ulb_q      <= cmd_ulb;
					urb_q      <= cmd_urb;
					vlb_q      <= cmd_vlb;
					vub_q      <= cmd_vub;
					left_q     <= '0;
					right_q    <= {1'b0, count_q} - {{(SW-1){1'b0}}, 1'b1};
					best_q     <= '1;
					found_q    <= 1'b0;
					over_q     <= 1'b0;
					emit_cnt_q <= '0;
					pass_q     <= 1'b0;
				end
			end
			ST_SEARCH: begin
				mid_q <= mid;
			end
			ST_PROBE: begin
				if (u_hi) begin
					right_q <= mid_q - SW'(1);
				end else if (u_lo) begin
					left_q <= mid_q + SW'(1);
				end else begin
					i_q    <= mid_q;
					pass_q <= 1'b0;
				end
			end
			ST_SCAN_RD: begin
				if (!idx_ok && !pass_q) begin
					pass_q <= 1'b1;
					i_q    <= mid_q - SW'(1);
				end
			end
			ST_SCAN_CHK: begin
				if (!chk_stall) begin
					if (scan_cont) begin
						i_q <= pass_q ? (i_q - SW'(1)) : (i_q + SW'(1));
						if (is_match) begin
							found_q <= 1'b1;
							if (need_emit) begin
								emit_cnt_q <= emit_cnt_q + EW'(1);
							end else begin
								over_q <= 1'b1;
							end
						end
					end else if (!pass_q) begin
						pass_q <= 1'b1;
						i_q    <= mid_q - SW'(1);
					end
				end
			end
			default: ;
		endcase
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (load_match) begin
			out_u_q     <= u_rd;
			out_v_q     <= v_rd;
			out_idx_q   <= idx_wide[INDEX_BITS-1:0];
			out_dist_q  <= '0;
			out_found_q <= 1'b0;
			out_over_q  <= 1'b0;
			out_last_q  <= 1'b0;
		end else if (load_sum) begin
			out_u_q     <= '0;
			out_v_q     <= '0;
			out_idx_q   <= '0;
			out_dist_q  <= best_q;
			out_found_q <= found_q;
			out_over_q  <= over_q;
			out_last_q  <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_BITS'({out_dist_q, out_idx_q, out_v_q, out_u_q});
	assign m_tuser  = {out_over_q, out_found_q};
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (emit_cnt_q <= EW'(MAX_MATCHES)))
		else $error("match counter past its limit");

	a_over_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && over_q) |-> found_q)
		else $error("overflow without any match");

	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (count_q < CW'(MAX_POINTS)))
		else $error("table write past its end");

	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !ram_we)
		else $error("table written during a query");

	a_empty_summary: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_last_q && !out_found_q) |-> (out_dist_q == '1))
		else $error("summary without match carries a distance");
`endif

endmodule

>>> rtl/core/sorted_window_point_search_core.sv
`timescale 1ns / 1ps
// top level of the sorted window point search core
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  s_tdata: point_u, point_v, query_u, query_v, radius
//                                   s_tuser: req_type
// m_*       out  m_tvalid/m_tready  m_tdata: match_u, match_v, match_index, min_distance
//                                   m_tuser: found, overflow   m_tlast: last
//
// clear and append are handled in the idle state of the back end at the queue head
// a query runs search probes (at most log2(MAX_POINTS) + 1), and on a hit a scan
// right from the hit and left from the point before it, then drain and summary; probes
// and scan reads go through the single registered read port of the point table
// the two-entry command queue takes words until full while the back end runs a query
// a stalled output word holds the scan in place; arst_n clears queue, count and state
module sorted_window_point_search_core #(
	parameter int MAX_POINTS  = swps_pkg::DEF_MAX_POINTS,
	parameter int COORD_BITS  = swps_pkg::DEF_COORD_BITS,
	parameter int MAX_MATCHES = swps_pkg::DEF_MAX_MATCHES
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// point_u, point_v, query_u, query_v, radius from bit 0 up, zero padded to bytes
	input  logic [((5 * COORD_BITS - 1 + 7) / 8) * 8 - 1:0] s_tdata,
	// req_type
	input  logic [swps_pkg::REQ_TYPE_BITS-1:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// match_u, match_v, match_index, min_distance from bit 0 up, zero padded to bytes
	output logic [((3 * COORD_BITS + 11 + 7) / 8) * 8 - 1:0] m_tdata,
	// found, overflow from bit 0 up
	output logic [swps_pkg::OUT_USER_BITS-1:0] m_tuser,
	// last: summary word that ends a query
	output logic m_tlast
);
	import swps_pkg::*;

	localparam int IN_DATA_BITS  = ((5 * COORD_BITS - 1 + 7) / 8) * 8;
	localparam int OUT_DATA_BITS = ((3 * COORD_BITS + 11 + 7) / 8) * 8;

	// queue head handed from front to back
	cmd_ctrl_t                 cmd;
	logic                      cmd_ready;
	logic [COORD_BITS-1:0]     cmd_a_u, cmd_a_v;
	logic signed [COORD_BITS:0] cmd_ulb, cmd_urb, cmd_vlb, cmd_vub;

	// decode and queue incoming request words
	swps_front #(
		.COORD_BITS  (COORD_BITS),
		.IN_DATA_BITS(IN_DATA_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd      (cmd),
		.cmd_ready(cmd_ready),
		.cmd_a_u  (cmd_a_u),
		.cmd_a_v  (cmd_a_v),
		.cmd_ulb  (cmd_ulb),
		.cmd_urb  (cmd_urb),
		.cmd_vlb  (cmd_vlb),
		.cmd_vub  (cmd_vub)
	);

	// table upkeep, search, scan and result words
	swps_back #(
		.MAX_POINTS   (MAX_POINTS),
		.COORD_BITS   (COORD_BITS),
		.MAX_MATCHES  (MAX_MATCHES),
		.OUT_DATA_BITS(OUT_DATA_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cmd_ready(cmd_ready),
		.cmd_a_u  (cmd_a_u),
		.cmd_a_v  (cmd_a_v),
		.cmd_ulb  (cmd_ulb),
		.cmd_urb  (cmd_urb),
		.cmd_vlb  (cmd_vlb),
		.cmd_vub  (cmd_vub),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

>>> test/tb_sorted_window_point_search_core.sv
`timescale 1ns / 1ps
// self-checking testbench of the sorted window point search core
module tb_sorted_window_point_search_core;
	import swps_pkg::*;

	localparam int MAX_PTS = DEF_MAX_POINTS;
	localparam int CB      = DEF_COORD_BITS;
	localparam int MAX_HIT = DEF_MAX_MATCHES;
	localparam int S_W     = ((5 * CB - 1 + 7) / 8) * 8;
	localparam int M_W     = ((3 * CB + 11 + 7) / 8) * 8;
	localparam int C_MIN   = -(1 << (CB - 1));
	localparam int C_MAX   = (1 << (CB - 1)) - 1;
	localparam int DIST_NONE = (1 << (CB + 1)) - 1;
	// request code that the block must ignore
	localparam logic [REQ_TYPE_BITS-1:0] REQ_UNUSED = 2'd3;
	// cycles without any accepted word before the run is declared hung
	localparam int STALL_LIMIT = 20000;
	// settle time once the last expected word is in
	localparam int SETTLE_CYCLES = 200;

	// one output word as predicted
	typedef struct packed {
		logic [CB-1:0]         u;
		logic [CB-1:0]         v;
		logic [INDEX_BITS-1:0] idx;
		logic [CB:0]           dist_min;
		logic                  found;
		logic                  over;
		logic                  last;
	} result_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_W-1:0] s_tdata = '0;
	logic [REQ_TYPE_BITS-1:0] s_tuser = REQ_CLEAR;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_W-1:0] m_tdata;
	logic [OUT_USER_BITS-1:0] m_tuser;
	logic m_tlast;

	// point table as the block should hold it
	int tab_u [MAX_PTS];
	int tab_v [MAX_PTS];
	int tab_count = 0;

	result_word_t pending_words [$];
	int mismatches = 0;
	// no idling on either side while set
	bit calm = 1'b0;

	sorted_window_point_search_core #(
		.MAX_POINTS (MAX_PTS),
		.COORD_BITS (CB),
		.MAX_MATCHES(MAX_HIT)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	// 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// receiver backpressure, about 14 stalls in a hundred unless calm
	always @(posedge clk) begin
		m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 14);
	end

	function automatic int clamp_coord(input int x);
		return (x < C_MIN) ? C_MIN : ((x > C_MAX) ? C_MAX : x);
	endfunction

	function automatic int rand_coord();
		logic [CB-1:0] raw;
		raw = CB'($urandom);
		return int'($signed(raw));
	endfunction

	// fields from bit 0 up: point_u, point_v, query_u, query_v, radius, zero pad
	function automatic logic [S_W-1:0] pack_request(input int pu, input int pv,
			input int qu, input int qv, input int r);
		logic [S_W-1:0] w;
		w = '0;
		w[CB-1:0]      = pu[CB-1:0];
		w[2*CB-1:CB]   = pv[CB-1:0];
		w[3*CB-1:2*CB] = qu[CB-1:0];
		w[4*CB-1:3*CB] = qv[CB-1:0];
		w[5*CB-2:4*CB] = r[CB-2:0];
		return w;
	endfunction

	// append one word to the expected output
	function automatic void add_expected(input result_word_t w);
		pending_words.insert(pending_words.size(), w);
	endfunction

	// expected output of one accepted request word
	function automatic void predict_request(input logic [REQ_TYPE_BITS-1:0] kind,
			input logic [S_W-1:0] data);
		int qu, qv, r, u_lo, u_hi, v_lo, v_hi, best, lo, hi, mid, i, d, sent, pass;
		bit hit, over, done;
		result_word_t w;
		case (kind)
			REQ_CLEAR: begin
				tab_count = 0;
			end
			REQ_APPEND: begin
				// a full table drops the point
				if (tab_count < MAX_PTS) begin
					tab_u[tab_count] = int'($signed(data[CB-1:0]));
					tab_v[tab_count] = int'($signed(data[2*CB-1:CB]));
					tab_count++;
				end
			end
			REQ_QUERY: begin
				qu = int'($signed(data[3*CB-1:2*CB]));
				qv = int'($signed(data[4*CB-1:3*CB]));
				r = int'(data[5*CB-2:4*CB]);
				u_lo = qu - r;
				u_hi = qu + r;
				v_lo = qv - r;
				v_hi = qv + r;
				best = DIST_NONE;
				sent = 0;
				hit = 1'b0;
				over = 1'b0;
				done = 1'b0;
				lo = 0;
				hi = tab_count - 1;
				while (lo <= hi && !done) begin
					mid = (lo + hi) / 2;
					if (tab_u[mid] > u_hi) begin
						hi = mid - 1;
					end else if (tab_u[mid] < u_lo) begin
						lo = mid + 1;
					end else begin
						// scan right from the hit, then left from the one before it
						for (pass = 0; pass < 2; pass++) begin
							i = (pass == 0) ? mid : mid - 1;
							while ((pass == 0) ? (i <= hi && tab_u[i] <= u_hi)
									: (i >= lo && tab_u[i] >= u_lo)) begin
								if (tab_v[i] > v_lo && tab_v[i] < v_hi) begin
									d = ((tab_u[i] < qu) ? qu - tab_u[i] : tab_u[i] - qu)
										+ ((tab_v[i] < qv) ? qv - tab_v[i] : tab_v[i] - qv);
									hit = 1'b1;
									if (d < best) best = d;
									if (sent < MAX_HIT) begin
										w = '0;
										w.u = tab_u[i][CB-1:0];
										w.v = tab_v[i][CB-1:0];
										w.idx = i[INDEX_BITS-1:0];
										add_expected(w);
										sent++;
									end else begin
										over = 1'b1;
									end
								end
								i = (pass == 0) ? i + 1 : i - 1;
							end
						end
						done = 1'b1;
					end
				end
				w = '0;
				w.dist_min = best[CB:0];
				w.found = hit;
				w.over = over;
				w.last = 1'b1;
				add_expected(w);
			end
			default: ;
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [CB:0] want,
			input logic [CB:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	// checker and predictor, both on words accepted at this edge
	always @(posedge clk) begin
		result_word_t w;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_words.size() == 0) begin
					$error("output word with nothing expected");
					mismatches++;
				end else begin
					w = pending_words.pop_front();
					check_field("match_u", (CB + 1)'(w.u), (CB + 1)'(m_tdata[CB-1:0]));
					check_field("match_v", (CB + 1)'(w.v), (CB + 1)'(m_tdata[2*CB-1:CB]));
					check_field("match_index", (CB + 1)'(w.idx),
						(CB + 1)'(m_tdata[2*CB+INDEX_BITS-1:2*CB]));
					check_field("min_distance", w.dist_min,
						m_tdata[3*CB+INDEX_BITS:2*CB+INDEX_BITS]);
					check_field("found", (CB + 1)'(w.found), (CB + 1)'(m_tuser[0]));
					check_field("overflow", (CB + 1)'(w.over), (CB + 1)'(m_tuser[1]));
					check_field("last", (CB + 1)'(w.last), (CB + 1)'(m_tlast));
				end
			end
			if (s_tvalid && s_tready) predict_request(s_tuser, s_tdata);
		end
	end

	// watchdog on cycles with no word moving on either side
	initial begin
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
			else quiet++;
		end
		$error("no word moved for %0d cycles", STALL_LIMIT);
		$display("status: fail");
		$finish;
	end

	// one request word, with random idle cycles ahead of it
	task automatic send_word(input logic [REQ_TYPE_BITS-1:0] kind,
			input logic [S_W-1:0] data);
		while (!calm && $urandom_range(0, 99) < 14) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= data;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// unused fields carry random junk
	task automatic send_clear();
		send_word(REQ_CLEAR, pack_request(rand_coord(), rand_coord(), rand_coord(),
			rand_coord(), rand_coord()));
	endtask

	task automatic send_append(input int u, input int v);
		send_word(REQ_APPEND, pack_request(u, v, rand_coord(), rand_coord(), rand_coord()));
	endtask

	task automatic send_query(input int qu, input int qv, input int r);
		send_word(REQ_QUERY, pack_request(rand_coord(), rand_coord(), qu, qv, r));
	endtask

	// sender holds off until every expected word is out
	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0) @(posedge clk);
	endtask

	// empty table, ignored code, clear on empty
	task automatic test_empty_table();
		send_query(0, 0, 100);
		send_word(REQ_UNUSED, pack_request(rand_coord(), rand_coord(), rand_coord(),
			rand_coord(), rand_coord()));
		send_clear();
		send_query(C_MAX, C_MIN, C_MAX);
	endtask

	// extremes, strict v bounds, zero radius and an out of order point
	task automatic test_directed_window();
		send_clear();
		send_append(C_MIN, 0);
		send_append(-16, C_MIN);
		send_append(0, C_MAX);
		send_append(0, 5);
		send_append(16, -3);
		send_append(C_MAX, C_MAX);
		send_query(0, 0, 0);
		send_query(0, 0, 16);
		send_query(0, 0, C_MAX);
		send_query(C_MIN, C_MIN, C_MAX);
		send_query(C_MAX, C_MAX, C_MAX);
		send_query(0, 5, 5);
		// v sits exactly on the lower edge, so no match
		send_query(0, 10, 5);
		send_query(300000, 0, 10);
		send_word(REQ_UNUSED, pack_request(1, 1, 0, 0, 8));
		// table no longer sorted from here on
		send_append(-100, 0);
		send_query(-100, 0, 1);
		send_query(C_MIN, 0, 0);
	endtask

	// full table, dropped appends, more than the emitted number of matches
	task automatic test_full_table();
		int i;
		send_clear();
		calm = 1'b1;
		for (i = 0; i < MAX_PTS; i++) begin
			send_append(C_MIN + i * 1024, $urandom_range(0, 4000) - 2000);
		end
		calm = 1'b0;
		send_append(C_MAX, 0);
		send_append(C_MIN, 0);
		send_query(0, 0, C_MAX);
		send_query(C_MIN, tab_v[0], 100);
		send_query(tab_u[MAX_PTS-1], tab_v[MAX_PTS-1], 100);
		send_query(tab_u[512], tab_v[512], 0);
		send_query(tab_u[300], 0, 5000);
	endtask

	// sorted runs with queries aimed at them, plus noise and broken runs
	task automatic test_random_windows(input int n_items);
		int sent, pick, n, i, top_u, scale, vc, qu, qv, r, k;
		bit drained;
		sent = 0;
		drained = 1'b0;
		top_u = C_MIN;
		scale = 16;
		vc = 0;
		send_clear();
		while (sent < n_items) begin
			calm = (sent > n_items / 3 && sent < n_items / 2);
			if (!drained && sent >= n_items / 2) begin
				wait_for_drain();
				drained = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				send_clear();
				top_u = rand_coord();
				sent++;
			end else if (pick < 16) begin
				case ($urandom_range(0, 2))
					0: send_word(REQ_UNUSED, pack_request(rand_coord(), rand_coord(),
						rand_coord(), rand_coord(), rand_coord()));
					1: begin
						send_append(rand_coord(), rand_coord());
						sent++;
					end
					default: begin
						send_query(rand_coord(), rand_coord(), rand_coord());
						sent++;
					end
				endcase
			end else begin
				if ($urandom_range(0, 1) == 0) begin
					send_clear();
					top_u = rand_coord();
					sent++;
				end
				// mostly short runs, now and then a long one that can overflow
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 12);
				scale = 1 << $urandom_range(2, 17);
				vc = rand_coord();
				for (i = 0; i < n; i++) begin
					top_u = clamp_coord(top_u + $urandom_range(0, scale));
					send_append(top_u, clamp_coord(vc + $urandom_range(0, 2 * scale) - scale));
					sent++;
				end
				for (i = $urandom_range(1, 4); i > 0; i--) begin
					if (tab_count > 0) begin
						k = $urandom_range(0, tab_count - 1);
						qu = clamp_coord(tab_u[k] + $urandom_range(0, 2 * scale) - scale);
						qv = clamp_coord(tab_v[k] + $urandom_range(0, 2 * scale) - scale);
					end else begin
						qu = rand_coord();
						qv = rand_coord();
					end
					case ($urandom_range(0, 4))
						0: r = $urandom_range(0, scale);
						1: r = $urandom_range(0, 524287);
						default: r = $urandom_range(scale, scale * (n + 2));
					endcase
					if (r > C_MAX) r = C_MAX;
					send_query(qu, qv, r);
					sent++;
				end
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_directed_window();
		test_full_table();
		test_random_windows(200);
		s_tvalid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/core/swps_pkg.sv
rtl/core/swps_ram.sv
rtl/core/swps_front.sv
rtl/core/swps_back.sv
rtl/core/sorted_window_point_search_core.sv
test/tb_sorted_window_point_search_core.sv
